>>> hdl/mctt_pkg.sv
// Shared types and constants of the tick timer table.
package mctt_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int TICK_W = 26;
  localparam logic [31:0] GRAN_FINE = 32'd100;
  localparam logic [31:0] GRAN_COARSE = 32'd1000;

  // floor(x / granule) == (x * RECIP) >> SH for every 32-bit x
  localparam logic [31:0] RECIP_FINE = 32'h51EB_851F;
  localparam logic [31:0] RECIP_COARSE = 32'h1062_4DD3;
  localparam int SH_FINE = 37;
  localparam int SH_COARSE = 38;

  typedef enum logic [1:0] {
    MODE_SET = 2'd0,
    MODE_KILL = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_TICK = 2'd3
  } mode_t;

  localparam logic [1:0] KIND_SET = 2'd0;
  localparam logic [1:0] KIND_KILL = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_EXPIRY = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] REG_GRANULE = 2'd0;

  typedef struct packed {
    logic [1:0] mode;
    logic [31:0] timer_id;
    logic [31:0] elapse_ms;
    logic single_shot;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [31:0] event_timer_id;
    logic [1:0] status;
    logic last;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [1:0] mode;
    logic [31:0] timer_id;
    logic [TICK_W-1:0] ticks;
    logic single_shot;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FIND,
    B_TDEC,
    B_TSCAN,
    B_TEMIT
  } back_state_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_t;
endpackage

>>> hdl/mctt_front.sv
// Front: accepts items and converts set periods to granule ticks.
module mctt_front (
  input  logic clk,
  input  logic rst,
  input  logic granule,
  input  logic push,
  output logic full,
  input  mctt_pkg::in_item_t item,
  output logic cmd_valid,
  input  logic cmd_ready,
  output mctt_pkg::cmd_t cmd
);
  import mctt_pkg::*;

  front_state_t state, state_next;
  in_item_t held;
  logic coarse;
  logic [31:0] gran_in;
  logic [31:0] num;
  logic [31:0] recip;
  logic [63:0] prod;
  logic [TICK_W-1:0] ticks;

  assign full = (state != F_IDLE);
  assign cmd_valid = (state == F_PUSH);
  assign gran_in = granule ? GRAN_COARSE : GRAN_FINE;
  assign recip = coarse ? RECIP_COARSE : RECIP_FINE;
  assign ticks = coarse ? prod[SH_COARSE+TICK_W-1:SH_COARSE] : prod[SH_FINE+TICK_W-1:SH_FINE];

  always_comb begin
    cmd.mode = held.mode;
    cmd.timer_id = held.timer_id;
    cmd.ticks = ticks;
    cmd.single_shot = held.single_shot;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (push) begin
        state_next = (mode_t'(item.mode) == MODE_SET) ? F_MUL : F_PUSH;
      end
      F_MUL: state_next = F_PUSH;
      F_PUSH: if (cmd_ready) begin
        state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // period clamp on pickup, then reciprocal multiply in F_MUL
  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      held <= item;
      coarse <= granule;
      num <= (item.elapse_ms < gran_in) ? gran_in : item.elapse_ms;
    end else if (state == F_MUL) begin
      prod <= 64'(num) * 64'(recip);
    end
  end
endmodule

>>> hdl/mctt_queue.sv
// Two-entry command queue between front and back.
module mctt_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  mctt_pkg::cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output mctt_pkg::cmd_t out_cmd
);
  import mctt_pkg::*;

  cmd_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wp] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end
endmodule

>>> hdl/mctt_back.sv
// Back: slot table, lookups, tick countdown and ordered expiry.
module mctt_back #(
  parameter int SLOTS = mctt_pkg::SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  mctt_pkg::cmd_t cmd,
  output logic empty,
  input  logic pop,
  output mctt_pkg::out_item_t result
);
  import mctt_pkg::*;
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  back_state_t state, state_next;
  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] fire;
  logic [31:0] key [SLOTS];
  logic [TICK_W-1:0] period [SLOTS];
  logic [TICK_W-1:0] remain [SLOTS];
  logic [SLOTS-1:0] one_shot;

  cmd_t cur;
  logic [CW-1:0] idx;
  logic [IW-1:0] slot;
  logic found, have_free;
  logic [IW-1:0] hit_slot, free_slot;
  logic best_ok;
  logic [IW-1:0] best;
  logic [31:0] best_key;
  logic [31:0] last_key;
  logic [CW-1:0] nfire;
  logic [CW-1:0] emitted;
  logic obuf_full;
  out_item_t obuf;

  assign slot = idx[IW-1:0];
  assign cmd_ready = (state == B_IDLE);
  assign empty = !obuf_full;
  assign result = obuf;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (cmd_valid) begin
        state_next = (mode_t'(cmd.mode) == MODE_TICK) ? B_TDEC : B_FIND;
      end
      B_FIND: if (idx == CW'(SLOTS) && !obuf_full) begin
        state_next = B_IDLE;
      end
      B_TDEC: if (idx == CW'(SLOTS)) begin
        state_next = (nfire == '0) ? B_IDLE : B_TSCAN;
      end
      B_TSCAN: if (idx == CW'(SLOTS)) begin
        state_next = B_TEMIT;
      end
      B_TEMIT: if (!obuf_full) begin
        state_next = (emitted + CW'(1) == nfire) ? B_IDLE : B_TSCAN;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      valid <= '0;
      fire <= '0;
      obuf_full <= 1'b0;
      idx <= '0;
      nfire <= '0;
      emitted <= '0;
      found <= 1'b0;
      have_free <= 1'b0;
      best_ok <= 1'b0;
    end else begin
      state <= state_next;
      if (obuf_full && pop) obuf_full <= 1'b0;
      unique case (state)
        B_IDLE: begin
          idx <= '0;
          found <= 1'b0;
          have_free <= 1'b0;
          nfire <= '0;
          emitted <= '0;
          best_ok <= 1'b0;
          if (cmd_valid) cur <= cmd;
        end
        B_FIND: begin
          if (idx != CW'(SLOTS)) begin
            idx <= idx + CW'(1);
            if (valid[slot] && key[slot] == cur.timer_id) begin
              found <= 1'b1;
              hit_slot <= slot;
            end
            if (!valid[slot] && !have_free) begin
              have_free <= 1'b1;
              free_slot <= slot;
            end
          end else if (!obuf_full) begin
            obuf_full <= 1'b1;
            obuf.event_timer_id <= cur.timer_id;
            obuf.last <= 1'b1;
            unique case (mode_t'(cur.mode))
              MODE_SET: begin
                obuf.kind <= KIND_SET;
                if (found || have_free) begin
                  obuf.status <= ST_OK;
                  valid[found ? hit_slot : free_slot] <= 1'b1;
                  key[found ? hit_slot : free_slot] <= cur.timer_id;
                  period[found ? hit_slot : free_slot] <= cur.ticks;
                  remain[found ? hit_slot : free_slot] <= cur.ticks;
                  one_shot[found ? hit_slot : free_slot] <= cur.single_shot;
                end else begin
                  obuf.status <= ST_FULL;
                end
              end
              MODE_KILL: begin
                obuf.kind <= KIND_KILL;
                obuf.status <= found ? ST_OK : ST_NOT_FOUND;
                if (found) valid[hit_slot] <= 1'b0;
              end
              default: begin
                obuf.kind <= KIND_QUERY;
                obuf.status <= found ? ST_OK : ST_NOT_FOUND;
              end
            endcase
          end
        end
        B_TDEC: begin
          if (idx != CW'(SLOTS)) begin
            idx <= idx + CW'(1);
            fire[slot] <= valid[slot] && (remain[slot] <= TICK_W'(1));
            if (valid[slot]) begin
              if (remain[slot] <= TICK_W'(1)) begin
                remain[slot] <= '0;
                nfire <= nfire + CW'(1);
              end else begin
                remain[slot] <= remain[slot] - TICK_W'(1);
              end
            end
          end else begin
            idx <= '0;
            best_ok <= 1'b0;
          end
        end
        B_TSCAN: begin
          if (idx != CW'(SLOTS)) begin
            idx <= idx + CW'(1);
            if (fire[slot] && (!best_ok || key[slot] < best_key)) begin
              best_ok <= 1'b1;
              best <= slot;
              best_key <= key[slot];
            end
          end
        end
        B_TEMIT: begin
          if (!obuf_full) begin
            obuf_full <= 1'b1;
            obuf.kind <= KIND_EXPIRY;
            obuf.event_timer_id <= best_key;
            obuf.status <= ST_OK;
            obuf.last <= (emitted + CW'(1) == nfire);
            last_key <= best_key;
            emitted <= emitted + CW'(1);
            fire[best] <= 1'b0;
            if (one_shot[best]) valid[best] <= 1'b0;
            else remain[best] <= period[best];
            idx <= '0;
            best_ok <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_emit_fired: assert property (@(posedge clk) disable iff (rst)
    (state == B_TEMIT && !obuf_full) |-> (best_ok && fire[best]))
    else $error("expiry emitted for a slot that did not fire");
  a_order: assert property (@(posedge clk) disable iff (rst)
    (state == B_TEMIT && !obuf_full && emitted != '0) |-> (best_key > last_key))
    else $error("expiries out of key order");
  a_count: assert property (@(posedge clk) disable iff (rst)
    (state == B_TSCAN) |-> (emitted < nfire))
    else $error("scan past fired count");
endmodule

>>> hdl/multi_channel_tick_timer_table_top.sv
// Top level of the tick timer table.
// Items enter a front stage (full is high while it holds an item; a set passes through an
// extra reciprocal-multiply state that turns the clamped period into granule ticks), pass
// a two-entry queue, and run one at a time in a back sequencer that walks the SLOTS-entry
// table: set, kill and query go through pickup, scan and reply there; a tick counts down
// every slot and then runs one ordered key search per expiry.
// Results leave through a one-beat output register; a result left waiting stalls the back.
module multi_channel_tick_timer_table_top #(
  parameter int SLOTS = mctt_pkg::SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic push,
  output logic full,
  input  mctt_pkg::in_item_t in_item,
  output logic empty,
  input  logic pop,
  output mctt_pkg::out_item_t out_item
);
  import mctt_pkg::*;

  logic granule;
  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_GRANULE) ? {31'd0, granule} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      granule <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_GRANULE) begin
      granule <= pwdata[0];
    end
  end

  mctt_front u_front (
    .clk(clk), .rst(rst), .granule(granule), .push(push), .full(full),
    .item(in_item), .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  mctt_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
    .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
  );

  mctt_back #(.SLOTS(SLOTS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .empty(empty), .pop(pop), .result(out_item)
  );
endmodule

>>> bench/tb_multi_channel_tick_timer_table_top.sv
// Testbench for the tick timer table: directed table plus random beats, checked by a predictor.
module tb_multi_channel_tick_timer_table_top;
  import mctt_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int DRAIN_CYC = 300;
  localparam int HOLD_CYC = 400;
  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    mode_t mode;
    logic [31:0] id;
    logic [31:0] elapse;
    logic single;
    int n_exp;
    out_item_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;

  // timer table mirror
  logic granule;
  logic tbl_valid [NSLOT];
  logic [31:0] tbl_key [NSLOT];
  logic [TICK_W-1:0] tbl_period [NSLOT];
  logic [TICK_W-1:0] tbl_left [NSLOT];
  logic tbl_one [NSLOT];

  out_item_t pending_q[$];
  logic [31:0] key_pool [20];
  int errors = 0;
  int n_items = 0, n_results = 0, n_expiry = 0, n_full = 0;
  int hold_tok = 0, hold_seen = 0, hold_cnt = 0, rx_idle = 0, wdog = 0;
  bit quiet = 0;

  always #4 clk = ~clk;

  multi_channel_tick_timer_table_top u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int find_key(input logic [31:0] key);
    for (int i = 0; i < NSLOT; i++)
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic out_item_t mk(input logic [1:0] k, input logic [31:0] id,
                                   input logic [1:0] st, input logic l);
    out_item_t o;
    o.kind = k;
    o.event_timer_id = id;
    o.status = st;
    o.last = l;
    return o;
  endfunction

  // applies one beat to the mirror and returns the results it causes
  task automatic timer_step(input in_item_t it, output out_item_t res[$]);
    logic [31:0] gran, el;
    logic [TICK_W-1:0] ticks;
    logic fire [NSLOT];
    int s, cnt, best;
    res = {};
    case (mode_t'(it.mode))
      MODE_SET: begin
        gran = granule ? GRAN_COARSE : GRAN_FINE;
        el = (it.elapse_ms < gran) ? gran : it.elapse_ms;
        ticks = TICK_W'(el / gran);
        s = find_key(it.timer_id);
        if (s < 0)
          for (int i = 0; i < NSLOT; i++)
            if (!tbl_valid[i]) begin
              s = i;
              break;
            end
        if (s < 0) begin
          res.push_back(mk(KIND_SET, it.timer_id, ST_FULL, 1'b1));
          n_full++;
        end else begin
          tbl_valid[s] = 1'b1;
          tbl_key[s] = it.timer_id;
          tbl_period[s] = ticks;
          tbl_left[s] = ticks;
          tbl_one[s] = it.single_shot;
          res.push_back(mk(KIND_SET, it.timer_id, ST_OK, 1'b1));
        end
      end
      MODE_KILL: begin
        s = find_key(it.timer_id);
        if (s >= 0) tbl_valid[s] = 1'b0;
        res.push_back(mk(KIND_KILL, it.timer_id, s < 0 ? ST_NOT_FOUND : ST_OK, 1'b1));
      end
      MODE_QUERY: begin
        s = find_key(it.timer_id);
        res.push_back(mk(KIND_QUERY, it.timer_id, s < 0 ? ST_NOT_FOUND : ST_OK, 1'b1));
      end
      default: begin
        cnt = 0;
        for (int i = 0; i < NSLOT; i++) begin
          fire[i] = 1'b0;
          if (tbl_valid[i]) begin
            if (tbl_left[i] <= 1) begin
              tbl_left[i] = '0;
              fire[i] = 1'b1;
              cnt++;
            end else begin
              tbl_left[i] = tbl_left[i] - 1'b1;
            end
          end
        end
        for (int n = 0; n < cnt; n++) begin
          best = -1;
          for (int i = 0; i < NSLOT; i++)
            if (fire[i] && (best < 0 || tbl_key[i] < tbl_key[best])) best = i;
          fire[best] = 1'b0;
          res.push_back(mk(KIND_EXPIRY, tbl_key[best], ST_OK, n + 1 == cnt));
          if (tbl_one[best]) tbl_valid[best] = 1'b0;
          else tbl_left[best] = tbl_period[best];
        end
      end
    endcase
  endtask

  task automatic send_beat(input in_item_t it, input int n_exp, input out_item_t exp);
    out_item_t res[$];
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    timer_step(it, res);
    n_items++;
    if (n_exp < 0) begin
      foreach (res[i]) pending_q.push_back(res[i]);
    end else if (n_exp > 0) begin
      pending_q.push_back(exp);
    end
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic apb_write_granule(input logic val);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'(4 * REG_GRANULE);
    pwdata <= {31'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    granule = val;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[0] !== val) report($sformatf("granule readback %0h, wrote %0b", rd, val));
  endtask

  function automatic in_item_t rand_beat();
    in_item_t it;
    logic [31:0] gran;
    int r;
    gran = granule ? GRAN_COARSE : GRAN_FINE;
    r = $urandom_range(0, 99);
    it.mode = r < 40 ? MODE_SET : r < 50 ? MODE_KILL : r < 60 ? MODE_QUERY : MODE_TICK;
    it.timer_id = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 19)] : $urandom;
    case ($urandom_range(0, 9))
      0: it.elapse_ms = $urandom;
      1: it.elapse_ms = $urandom_range(0, gran - 1);
      default: it.elapse_ms = gran * $urandom_range(1, 4) + $urandom_range(0, gran - 1);
    endcase
    it.single_shot = $urandom_range(0, 1);
    return it;
  endfunction

  task automatic random_phase(input int n, input bit with_pressure);
    for (int i = 0; i < n; i++) begin
      if (with_pressure && i == 10) hold_tok <= hold_tok + 1;
      if (with_pressure && i == n / 2) drain();
      send_beat(rand_beat(), -1, '0);
      sender_gap();
    end
  endtask

  // result side: check and random pop pattern
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        n_results++;
        if (out_item.kind == KIND_EXPIRY) n_expiry++;
        if (pending_q.size() == 0) begin
          report($sformatf("unexpected beat %p", out_item));
        end else begin
          if (out_item.kind !== pending_q[0].kind)
            report($sformatf("kind %0d, want %0d", out_item.kind, pending_q[0].kind));
          if (out_item.event_timer_id !== pending_q[0].event_timer_id)
            report($sformatf("id %0h, want %0h", out_item.event_timer_id,
                             pending_q[0].event_timer_id));
          if (out_item.status !== pending_q[0].status)
            report($sformatf("status %0d, want %0d", out_item.status, pending_q[0].status));
          if (out_item.last !== pending_q[0].last)
            report($sformatf("last %0b, want %0b", out_item.last, pending_q[0].last));
          void'(pending_q.pop_front());
        end
      end
      if (hold_tok != hold_seen) begin
        hold_seen = hold_tok;
        hold_cnt = HOLD_CYC;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else if (rx_idle > 0) begin
        rx_idle--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_idle = $urandom_range(0, 7);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) wdog = 0;
      else wdog++;
      if (wdog >= WDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  row_t rows [22];

  initial begin
    rows = '{
      '{MODE_QUERY, 32'h0, 32'h0, 1'b0, 1, '{KIND_QUERY, 32'h0, ST_NOT_FOUND, 1'b1}},
      '{MODE_KILL, 32'hFFFF_FFFF, 32'h0, 1'b0, 1,
        '{KIND_KILL, 32'hFFFF_FFFF, ST_NOT_FOUND, 1'b1}},
      '{MODE_TICK, 32'h0, 32'h0, 1'b0, 0, '0},
      '{MODE_SET, 32'hFFFF_FFFF, 32'h0, 1'b1, 1, '{KIND_SET, 32'hFFFF_FFFF, ST_OK, 1'b1}},
      '{MODE_SET, 32'h0, 32'hFFFF_FFFF, 1'b0, 1, '{KIND_SET, 32'h0, ST_OK, 1'b1}},
      '{MODE_SET, 32'd5, 32'd99, 1'b0, 1, '{KIND_SET, 32'd5, ST_OK, 1'b1}},
      '{MODE_SET, 32'd5, 32'd250, 1'b1, 1, '{KIND_SET, 32'd5, ST_OK, 1'b1}},
      '{MODE_QUERY, 32'd5, 32'h0, 1'b0, 1, '{KIND_QUERY, 32'd5, ST_OK, 1'b1}},
      '{MODE_TICK, 32'h0, 32'h0, 1'b0, -1, '0},
      '{MODE_TICK, 32'h0, 32'h0, 1'b0, -1, '0},
      '{MODE_TICK, 32'h0, 32'h0, 1'b0, -1, '0},
      '{MODE_QUERY, 32'hFFFF_FFFF, 32'h0, 1'b0, 1,
        '{KIND_QUERY, 32'hFFFF_FFFF, ST_NOT_FOUND, 1'b1}},
      '{MODE_SET, 32'd3, 32'd100, 1'b0, 1, '{KIND_SET, 32'd3, ST_OK, 1'b1}},
      '{MODE_SET, 32'd1, 32'd150, 1'b0, 1, '{KIND_SET, 32'd1, ST_OK, 1'b1}},
      '{MODE_TICK, 32'h0, 32'h0, 1'b0, -1, '0},
      '{MODE_TICK, 32'h0, 32'h0, 1'b0, -1, '0},
      '{MODE_KILL, 32'd3, 32'h0, 1'b0, 1, '{KIND_KILL, 32'd3, ST_OK, 1'b1}},
      '{MODE_KILL, 32'd3, 32'h0, 1'b0, 1, '{KIND_KILL, 32'd3, ST_NOT_FOUND, 1'b1}},
      '{MODE_SET, 32'h0, 32'd200, 1'b1, 1, '{KIND_SET, 32'h0, ST_OK, 1'b1}},
      '{MODE_TICK, 32'h0, 32'h0, 1'b0, -1, '0},
      '{MODE_TICK, 32'h0, 32'h0, 1'b0, -1, '0},
      '{MODE_QUERY, 32'h0, 32'h0, 1'b0, 1, '{KIND_QUERY, 32'h0, ST_NOT_FOUND, 1'b1}}
    };
    granule = 1'b0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_write_granule(1'b0);
    foreach (rows[i]) begin
      in_item_t it;
      it.mode = rows[i].mode;
      it.timer_id = rows[i].id;
      it.elapse_ms = rows[i].elapse;
      it.single_shot = rows[i].single;
      send_beat(it, rows[i].n_exp, rows[i].exp);
      sender_gap();
    end
    drain();

    apb_write_granule(1'b1);
    random_phase(50, 0);
    drain();
    apb_write_granule(1'b0);
    random_phase(60, 1);
    drain();
    apb_write_granule(1'b1);
    quiet = 1;
    random_phase(40, 0);
    drain();

    $display("Covered %0d beats in, %0d results out (%0d expiries, %0d table-full replies)",
             n_items, n_results, n_expiry, n_full);
    $display("across both granules, a long output stall and a full drain mid-run");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
